### hw/rtl/sorted_deadline_timer_queue_core_macros.svh
// Assertion macros for the sorted deadline timer queue.
// The enclosing module must provide clk and the synchronous active-low rst_n.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define SDTQ_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SDTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SDTQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sdtq_pkg.sv
// Package for the sorted deadline timer queue: sizes, codes and word types.
// Used by sorted_deadline_timer_queue_core; depends on nothing.
`default_nettype none

package sdtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HINT_EN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT = 1'd1;

  localparam logic       HINT_EN_RST  = 1'b1;
  localparam logic [7:0] MAX_WAIT_RST = 8'd20;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_POLL     = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_ID_ZERO  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] entry_id;
    logic [31:0] deadline;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      out_id;
    logic [31:0]      out_deadline;
    logic [7:0]       wait_hint;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_deadline_timer_queue_core.sv
// One shared compare/subtract unit walks the slots, reading a slot and then comparing or
// writing it; an id of zero is answered without a walk, and a stalled output word holds
// the reply in S_OUT until the stall lifts.
// One word is in work at a time; the next is accepted in the cycle after the reply loads.
// Reset (rst_n low, synchronous) empties the queue, drops any output word, enables wait
// hints and sets max_wait to 20; slot contents are not cleared.
`default_nettype none
`include "sorted_deadline_timer_queue_core_macros.svh"

module sorted_deadline_timer_queue_core (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  sdtq_pkg::in_word_t                     in_data,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output sdtq_pkg::out_word_t                    out_data,
  input  wire                                    cfg_we,
  input  wire  [sdtq_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [sdtq_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import sdtq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_DEL   = 7'b0000100,
    S_PLACE = 7'b0001000,
    S_SHR   = 7'b0010000,
    S_HEAD  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // Slot memory: one write and one registered read per cycle.
  logic [31:0] mem_id [QUEUE_DEPTH];
  logic [31:0] mem_dl [QUEUE_DEPTH];
  logic [31:0] rd_id_r, rd_dl_r;

  state_t           state_r, state_nxt;
  logic             ph_r, ph_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  in_word_t         item_r, item_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      oid_r, oid_nxt;
  logic [31:0]      odl_r, odl_nxt;
  logic [7:0]       hint_r, hint_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;
  logic             eco_r;
  logic [7:0]       maxw_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_id, wr_dl;
  logic [IDX_W-1:0] rd_addr;

  logic [31:0]      sub_a, sub_b, diff, wait_ms;
  logic [CNT_W-1:0] idx_inc, idx_dec;
  logic [7:0]       capped;
  logic             in_take;

  // Shared wrap-aware comparator: a is before b when (a - b) is negative.
  always_comb begin
    if (state_r == S_PLACE && idx_r != '0) begin
      sub_a = rd_dl_r;
      sub_b = item_r.deadline;
    end else if (state_r == S_PLACE) begin
      sub_a = item_r.deadline;
      sub_b = rd_dl_r;
    end else begin
      sub_a = item_r.now_ms;
      sub_b = rd_dl_r;
    end
  end
  assign diff    = sub_a - sub_b;
  // deadline - now - 1 equals the complement of now - deadline.
  assign wait_ms = ~diff;
  assign capped  = ((|wait_ms[31:8]) || (wait_ms[7:0] > maxw_r)) ? maxw_r : wait_ms[7:0];

  assign idx_inc = idx_r + CNT_W'(1);
  assign idx_dec = idx_r - CNT_W'(1);
  assign in_take = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    status_nxt    = status_r;
    oid_nxt       = oid_r;
    odl_nxt       = odl_r;
    hint_nxt      = hint_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_id         = rd_id_r;
    wr_dl         = rd_dl_r;
    rd_addr       = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          item_nxt   = in_data;
          status_nxt = ST_DONE;
          oid_nxt    = '0;
          odl_nxt    = '0;
          hint_nxt   = '0;
          idx_nxt    = '0;
          ph_nxt     = 1'b0;
          if (in_data.op == OP_POLL) begin
            if (cnt_r == '0) begin
              status_nxt = ST_NONE;
              hint_nxt   = eco_r ? maxw_r : 8'd0;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = S_HEAD;
            end
          end else if (in_data.entry_id == '0) begin
            status_nxt = ST_ID_ZERO;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      S_FIND: begin
        if (!ph_r) begin
          if (idx_r == cnt_r) begin
            // The id is not held.
            if (item_r.op == OP_REGISTER) begin
              if (cnt_r >= CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_OUT;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_PLACE;
              end
            end else begin
              status_nxt = ST_NONE;
              state_nxt  = S_OUT;
            end
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if (rd_id_r == item_r.entry_id) begin
            if (item_r.op == OP_QUERY) begin
              odl_nxt   = rd_dl_r;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_DEL;
            end
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end

      S_DEL: begin
        // Close the gap at idx by moving later slots down one place.
        if (!ph_r) begin
          if (idx_inc >= cnt_r) begin
            cnt_nxt = cnt_r - CNT_W'(1);
            if (item_r.op == OP_REGISTER) begin
              idx_nxt   = '0;
              state_nxt = S_PLACE;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            rd_addr = idx_inc[IDX_W-1:0];
            ph_nxt  = 1'b1;
          end
        end else begin
          wr_en   = 1'b1;
          idx_nxt = idx_inc;
          ph_nxt  = 1'b0;
        end
      end

      S_PLACE: begin
        // The new word goes ahead of equal deadlines, except an equal head.
        if (!ph_r) begin
          if (idx_r == cnt_r) begin
            pos_nxt   = cnt_r;
            idx_nxt   = cnt_r;
            state_nxt = S_SHR;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if ((idx_r == '0) ? diff[31] : !diff[31]) begin
            pos_nxt   = idx_r;
            idx_nxt   = cnt_r;
            state_nxt = S_SHR;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end

      S_SHR: begin
        // Open a gap at pos by moving slots up one place, top first.
        if (!ph_r) begin
          if (idx_r == pos_r) begin
            wr_en     = 1'b1;
            wr_addr   = pos_r[IDX_W-1:0];
            wr_id     = item_r.entry_id;
            wr_dl     = item_r.deadline;
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = S_OUT;
          end else begin
            rd_addr = idx_dec[IDX_W-1:0];
            ph_nxt  = 1'b1;
          end
        end else begin
          wr_en   = 1'b1;
          idx_nxt = idx_dec;
          ph_nxt  = 1'b0;
        end
      end

      S_HEAD: begin
        if (!ph_r) begin
          rd_addr = '0;
          ph_nxt  = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (diff[31]) begin
            status_nxt = ST_NONE;
            hint_nxt   = eco_r ? capped : 8'd0;
            state_nxt  = S_OUT;
          end else begin
            oid_nxt   = rd_id_r;
            odl_nxt   = rd_dl_r;
            idx_nxt   = '0;
            state_nxt = S_DEL;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.status       = status_r;
          out_data_nxt.out_id       = oid_r;
          out_data_nxt.out_deadline = odl_r;
          out_data_nxt.wait_hint    = hint_r;
          out_data_nxt.occupancy    = OCC_W'(cnt_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr] <= wr_id;
      mem_dl[wr_addr] <= wr_dl;
    end
    rd_id_r <= mem_id[rd_addr];
    rd_dl_r <= mem_dl[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      eco_r       <= HINT_EN_RST;
      maxw_r      <= MAX_WAIT_RST;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_HINT_EN:  eco_r  <= cfg_wdata[0];
          CFG_MAX_WAIT: maxw_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    item_r     <= item_nxt;
    status_r   <= status_nxt;
    oid_r      <= oid_nxt;
    odl_r      <= odl_nxt;
    hint_r     <= hint_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SDTQ_ASSERT_NOW(a_cnt_bound, cnt_r <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `SDTQ_ASSERT_IMP(a_del_nonempty, state_r == S_DEL, cnt_r != '0, "delete on empty queue")
  `SDTQ_ASSERT_NXT(a_take_busy, in_take, state_r != S_IDLE, "accepted word left no work")
  `SDTQ_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(state_r == S_OUT),
                   "output word loaded outside the output state")

endmodule

`default_nettype wire

### test/sorted_deadline_timer_queue_core_test.sv
// Self-checking testbench for sorted_deadline_timer_queue_core: a directed plan, then
// phases of random timer traffic under several register settings, scored by a predictor or by fixed expected replies.
// Depends on sdtq_pkg and the core RTL only.
`default_nettype none

module sorted_deadline_timer_queue_core_test;
  import sdtq_pkg::*;

  localparam int CYCLE_LIMIT   = 1_300_000;
  localparam int SETTLE_CYCLES = 8 * QUEUE_DEPTH + 8;
  localparam int PHASE_WORDS   = 245;
  localparam int PRINT_CAP     = 50;
  localparam int RING_DEPTH    = 16;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sorted_deadline_timer_queue_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted contents of the timer queue, head at index 0.
  logic [31:0] slot_id_m [QUEUE_DEPTH];
  logic [31:0] slot_dl_m [QUEUE_DEPTH];
  int          live_cnt;
  logic        eco_m;
  logic [7:0]  max_wait_m;

  // Expected replies in order of acceptance; written and read through running counts.
  out_word_t   reply_ring [RING_DEPTH];
  int          ring_wr;
  int          ring_rd;
  int          idle_pct;
  int          cycle_cnt;
  int          mismatches;
  int          words_sent;
  int          replies_seen;
  int          timers_fired;
  int          full_drops;
  int          hinted_polls;

  typedef struct {
    in_word_t  word;
    int        reps;
    bit        typed;
    out_word_t want;
  } plan_row_t;

  typedef struct {
    logic        eco;
    int          max_wait;
    int          idle;
    int          reg_pct;
    int          poll_pct;
    logic [31:0] t0;
  } phase_t;

  plan_row_t plan [$];
  phase_t    phases [$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic int find_slot(input logic [31:0] id);
    for (int i = 0; i < live_cnt; i++)
      if (slot_id_m[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < live_cnt; i++) begin
      slot_id_m[i] = slot_id_m[i + 1];
      slot_dl_m[i] = slot_dl_m[i + 1];
    end
    live_cnt--;
  endfunction

  // Applies one word to the predicted queue and returns the reply it should produce.
  function automatic out_word_t timer_step(input in_word_t w);
    out_word_t   r;
    int          pos;
    int          p;
    logic [31:0] gap_ms;
    r = '0;
    if (w.op == OP_POLL) begin
      if (live_cnt == 0) begin
        r.status    = ST_NONE;
        r.wait_hint = eco_m ? max_wait_m : 8'd0;
      end else if (earlier(w.now_ms, slot_dl_m[0])) begin
        r.status = ST_NONE;
        if (eco_m) begin
          gap_ms      = slot_dl_m[0] - w.now_ms - 32'd1;
          r.wait_hint = (gap_ms > {24'd0, max_wait_m}) ? max_wait_m : gap_ms[7:0];
        end
      end else begin
        r.status       = ST_DONE;
        r.out_id       = slot_id_m[0];
        r.out_deadline = slot_dl_m[0];
        drop_slot(0);
        timers_fired++;
      end
      if (r.wait_hint != 8'd0) hinted_polls++;
    end else if (w.entry_id == 32'd0) begin
      r.status = ST_ID_ZERO;
    end else begin
      pos = find_slot(w.entry_id);
      if (w.op == OP_REGISTER) begin
        if (pos >= 0) drop_slot(pos);
        if (live_cnt >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
          full_drops++;
        end else begin
          // A new entry lands behind a head with the same deadline, but ahead of
          // any later entry with the same deadline.
          if (live_cnt == 0 || earlier(w.deadline, slot_dl_m[0])) begin
            p = 0;
          end else begin
            p = 1;
            while (p < live_cnt && earlier(slot_dl_m[p], w.deadline)) p++;
          end
          for (int i = live_cnt; i > p; i--) begin
            slot_id_m[i] = slot_id_m[i - 1];
            slot_dl_m[i] = slot_dl_m[i - 1];
          end
          slot_id_m[p] = w.entry_id;
          slot_dl_m[p] = w.deadline;
          live_cnt++;
        end
      end else if (pos < 0) begin
        r.status = ST_NONE;
      end else if (w.op == OP_REMOVE) begin
        drop_slot(pos);
      end else begin
        r.out_deadline = slot_dl_m[pos];
      end
    end
    r.occupancy = OCC_W'(live_cnt);
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [31:0] id,
                                  input logic [31:0] dl, input logic [31:0] now, input int reps);
    plan_row_t row;
    row.word  = '{op: op, entry_id: id, deadline: dl, now_ms: now};
    row.reps  = reps;
    row.typed = 1'b0;
    row.want  = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_fixed(input logic [1:0] op, input logic [31:0] id,
                                    input logic [31:0] dl, input logic [31:0] now,
                                    input logic [1:0] st, input logic [31:0] odl,
                                    input logic [7:0] hint, input int occ);
    plan_row_t row;
    row.word  = '{op: op, entry_id: id, deadline: dl, now_ms: now};
    row.reps  = 1;
    row.typed = 1'b1;
    row.want  = '{status: st, out_id: 32'd0, out_deadline: odl, wait_hint: hint,
                  occupancy: OCC_W'(occ)};
    plan.push_back(row);
  endfunction

  function automatic void add_phase(input logic eco, input int max_wait, input int idle,
                                    input int reg_pct, input int poll_pct, input logic [31:0] t0);
    phase_t ph;
    ph = '{eco: eco, max_wait: max_wait, idle: idle, reg_pct: reg_pct, poll_pct: poll_pct,
           t0: t0};
    phases.push_back(ph);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("cycle %0d, reply %0d: %s expected %0h, got %0h",
               cycle_cnt, replies_seen, what, want, got);
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int        gap;
    out_word_t guess;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    guess = timer_step(w);
    reply_ring[ring_wr % RING_DEPTH] = typed ? want : guess;
    ring_wr++;
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_HINT_EN) eco_m = val[0];
    else max_wait_m = val;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ring_wr != ring_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stall generator on the reply side; stalls come in bursts of random length.
  initial begin : reply_stall
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        hold = $urandom_range(1, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (ring_wr == ring_rd) begin
        report_mismatch("unexpected reply, status", 32'd0, {30'd0, out_data.status});
      end else begin
        want = reply_ring[ring_rd % RING_DEPTH];
        ring_rd++;
        if (out_data.status !== want.status)
          report_mismatch("status", {30'd0, want.status}, {30'd0, out_data.status});
        if (out_data.out_id !== want.out_id)
          report_mismatch("out_id", want.out_id, out_data.out_id);
        if (out_data.out_deadline !== want.out_deadline)
          report_mismatch("out_deadline", want.out_deadline, out_data.out_deadline);
        if (out_data.wait_hint !== want.wait_hint)
          report_mismatch("wait_hint", {24'd0, want.wait_hint}, {24'd0, out_data.wait_hint});
        if (out_data.occupancy !== want.occupancy)
          report_mismatch("occupancy", {27'd0, want.occupancy}, {27'd0, out_data.occupancy});
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timed out with %0d replies outstanding", ring_wr - ring_rd);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_word_t    w;
    logic [31:0] time_ms;
    int          pick;
    int          mw;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    idle_pct     = 0;
    mismatches   = 0;
    words_sent   = 0;
    replies_seen = 0;
    timers_fired = 0;
    full_drops   = 0;
    hinted_polls = 0;
    ring_wr      = 0;
    ring_rd      = 0;
    live_cnt     = 0;
    eco_m        = HINT_EN_RST;
    max_wait_m   = MAX_WAIT_RST;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_id_m[i] = '0;
      slot_dl_m[i] = '0;
    end

    // Directed plan, run with the reset register values.
    add_fixed(OP_POLL,     32'd0, 32'd0, 32'd0, ST_NONE, 32'd0, MAX_WAIT_RST, 0);
    add_fixed(OP_REGISTER, 32'd0, 32'd5, 32'd0, ST_ID_ZERO, 32'd0, 8'd0, 0);
    add_fixed(OP_REMOVE,   32'd0, 32'd0, 32'd0, ST_ID_ZERO, 32'd0, 8'd0, 0);
    add_fixed(OP_QUERY,    32'd0, 32'd0, 32'd0, ST_ID_ZERO, 32'd0, 8'd0, 0);
    add_fixed(OP_REGISTER, 32'hFFFF_FFFF, 32'd1000, 32'd0, ST_DONE, 32'd0, 8'd0, 1);
    add_row(OP_REGISTER, 32'd1, 32'd1000, 32'd0, 1);         // ties with the head
    add_row(OP_REGISTER, 32'd2, 32'd1000, 32'd0, 1);         // ties behind the head
    add_row(OP_REGISTER, 32'd3, 32'h8000_03E8, 32'd0, 1);    // exactly half a wrap away
    add_row(OP_REGISTER, 32'd1, 32'd0, 32'd0, 1);            // same id moves
    add_row(OP_REGISTER, 32'h100, 32'd2000, 32'd0, 12);      // fills the table
    add_fixed(OP_REGISTER, 32'h200, 32'd5, 32'd0, ST_FULL, 32'd0, 8'd0, QUEUE_DEPTH);
    add_row(OP_REGISTER, 32'd2, 32'hFFFF_FFFF, 32'd0, 1);    // same id on a full table
    add_fixed(OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0, ST_DONE, 32'd1000, 8'd0, QUEUE_DEPTH);
    add_row(OP_REMOVE, 32'h105, 32'd0, 32'd0, 1);
    add_row(OP_QUERY, 32'h105, 32'd0, 32'd0, 1);
    add_row(OP_POLL, 32'd0, 32'd0, 32'd0, 1);
    add_row(OP_POLL, 32'd0, 32'd0, 32'd1500, 1);
    add_row(OP_POLL, 32'd0, 32'd0, 32'hFFFF_FFFF, 1);

    // Register settings per random phase; a negative wait cap means a random one.
    add_phase(1'b0, 255, 20, 60, 15, 32'd0);
    add_phase(1'b1,   0,  0, 35, 40, 32'h0001_0000);
    add_phase(1'b1, 255, 30, 40, 35, 32'hFFFF_F000);
    add_phase(1'b0,   0, 10, 45, 30, 32'h4000_0000);
    add_phase(1'b1,  -1, 20, 40, 35, 32'h7FFF_F000);
    add_phase(1'b1,  20, 30, 30, 50, 32'h1234_5678);
    add_phase(1'b0,  -1, 10, 50, 25, 32'h8000_0000);
    add_phase(1'b1, 255,  0, 40, 35, 32'hFFFF_FF00);   // closing stretch, no stalls

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        w          = plan[r].word;
        w.entry_id = w.entry_id + k;
        w.deadline = w.deadline - 3 * k;
        send_word(w, plan[r].typed, plan[r].want);
      end
    end
    drain_replies();

    foreach (phases[ph]) begin
      mw = (phases[ph].max_wait < 0) ? $urandom_range(1, 254) : phases[ph].max_wait;
      write_reg(CFG_HINT_EN, {7'($urandom_range(0, 127)), phases[ph].eco});
      write_reg(CFG_MAX_WAIT, 8'(mw));
      idle_pct = phases[ph].idle;
      time_ms  = phases[ph].t0;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Unused fields carry random bits too.
        w.entry_id = $urandom;
        w.deadline = $urandom;
        w.now_ms   = $urandom;
        pick       = $urandom_range(0, 99);
        if (pick < phases[ph].reg_pct) w.op = OP_REGISTER;
        else if (pick < phases[ph].reg_pct + phases[ph].poll_pct) w.op = OP_POLL;
        else if (pick % 2 == 0) w.op = OP_REMOVE;
        else w.op = OP_QUERY;

        // Mostly a small pool of ids so that replace, remove and query hit.
        pick = $urandom_range(0, 99);
        if (pick < 4) w.entry_id = 32'd0;
        else if (pick < 7) w.entry_id = 32'hFFFF_FFFF - $urandom_range(0, 2);
        else if (pick >= 12) w.entry_id = $urandom_range(1, 24);

        if (w.op == OP_REGISTER && $urandom_range(0, 99) >= 8)
          w.deadline = time_ms + 32'($urandom_range(0, 80)) - 32'd20;
        if (w.op == OP_POLL && $urandom_range(0, 99) >= 5) begin
          time_ms  = time_ms + 32'($urandom_range(0, 12));
          w.now_ms = time_ms;
        end
        send_word(w, 1'b0, '0);
      end
      drain_replies();
    end

    $display("Sent %0d timer words over %0d register settings and the directed plan.",
             words_sent, phases.size());
    $display("Timers fired %0d, full-table drops %0d, idle polls with a wait hint %0d.",
             timers_fired, full_drops, hinted_polls);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/sdtq_pkg.sv
hw/rtl/sorted_deadline_timer_queue_core.sv
test/sorted_deadline_timer_queue_core_test.sv
